FILE: hdl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared codes, field widths and helpers of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

   localparam int MODE_W      = 2;
   localparam int HANDLE_W    = 64;
   localparam int STATUS_W    = 2;
   localparam int SLOT_IDX_W  = 12;
   localparam int COUNT_W     = 13;
   localparam int WORD_W      = 32;   // alive bits per memory row
   localparam int WORD_SEL_W  = 5;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESOLVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic                  found;
      logic [WORD_SEL_W-1:0] idx;
   } bit_pick_type;

   // lowest set bit of one row word
   function automatic bit_pick_type pick_lowest(input logic [WORD_W-1:0] v);
      bit_pick_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.idx   = WORD_SEL_W'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/gsa_req_if.sv
// ----------------------------------------------------------------------------
// gsa_req_if
// Request channel: mode and handle with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsa_req_if;
   import gsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, output mode, output handle, input ready);
   modport sink   (input valid, input mode, input handle, output ready);
endinterface

FILE: hdl/gsa_rsp_if.sv
// ----------------------------------------------------------------------------
// gsa_rsp_if
// Response channel: status, new handle, slot and live count.
// ----------------------------------------------------------------------------
interface gsa_rsp_if;
   import gsa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [HANDLE_W-1:0]   new_handle;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic [COUNT_W-1:0]    live_count;

   modport source (output valid, output status, output new_handle, output slot_index,
                   output live_count, input ready);
   modport sink   (input valid, input status, input new_handle, input slot_index,
                   input live_count, output ready);
endinterface

FILE: hdl/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Slot table with alive bits and generations; allocate, resolve and free.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories, one slot per cycle, before it
// takes its first request. Each request first reads the generation memory
// and the 32-bit alive row, then is checked, written back and loaded into
// the response register; that step waits while an older response is untaken.
// An allocate that takes the last free slot of its alive row then searches
// the following rows for the next lowest free slot, one alive memory row read
// and checked at a time, before the next request is taken. A new request is
// accepted while the previous response still waits to be taken.
module generational_slot_allocator #(
   parameter int SLOTS    = 4096,
   parameter int GEN_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   gsa_req_if.sink      req_chan,
   gsa_rsp_if.source    rsp_chan
);
   import gsa_pkg::*;

   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROWS      = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int LAST_BITS = SLOTS - WORD_W * (ROWS - 1);
   localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'd1 << LAST_BITS) - 64'd1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS);

   typedef enum logic [4:0] {
      S_CLEAR    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_EXEC     = 5'b00100,
      S_SCAN_RD  = 5'b01000,
      S_SCAN_CHK = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     clr_ff, clr_in;
   logic [SLOT_W-1:0]     hint_ff, hint_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ROW_W-1:0]      scan_row_ff, scan_row_in;
   logic [MODE_W-1:0]     mode_ff;
   logic [HANDLE_W-1:0]   handle_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  in_range_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [SLOT_IDX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // memory ports
   logic                  gen_wr_en, gen_rd_en;
   logic [SLOT_W-1:0]     gen_wr_addr, gen_rd_addr;
   logic [GEN_BITS-1:0]   gen_wr_data, gen_rd_data;
   logic                  alive_wr_en, alive_rd_en;
   logic [ROW_W-1:0]      alive_wr_addr, alive_rd_addr;
   logic [WORD_W-1:0]     alive_wr_data, alive_rd_data;

   // request decode
   logic                  req_fire;
   logic [31:0]           req_idx;
   logic                  req_in_range;
   logic [SLOT_W-1:0]     req_slot;

   // execute stage
   logic                  out_free, exec_go;
   logic [ROW_W-1:0]      slot_row, next_row;
   logic [WORD_SEL_W-1:0] slot_bit;
   logic [WORD_W-1:0]     slot_onehot, set_word, row_mask, scan_mask;
   logic                  handle_ok, is_full, free_ok;
   bit_pick_type          exec_pick, scan_pick;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign req_idx        = req_chan.handle[31:0];
   assign req_in_range   = (req_idx != 32'd0) && (req_idx <= 32'(SLOTS));
   assign req_slot       = (req_chan.mode == MODE_ALLOC) ? hint_ff : SLOT_W'(req_idx - 32'd1);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign exec_go  = (state_ff == S_EXEC) && out_free;

   assign slot_row    = ROW_W'(slot_ff >> WORD_SEL_W);
   assign slot_bit    = WORD_SEL_W'(slot_ff);
   assign slot_onehot = WORD_W'(1) << slot_bit;
   assign set_word    = alive_rd_data | slot_onehot;
   assign next_row    = (slot_row == ROW_LAST) ? '0 : slot_row + 1'b1;
   assign row_mask    = (slot_row == ROW_LAST) ? LAST_MASK : '1;
   assign scan_mask   = (scan_row_ff == ROW_LAST) ? LAST_MASK : '1;
   assign exec_pick   = pick_lowest(~set_word & row_mask);
   assign scan_pick   = pick_lowest(~alive_rd_data & scan_mask);

   assign handle_ok = in_range_ff && alive_rd_data[slot_bit]
                      && (handle_ff[63:32] == 32'(gen_rd_data));
   assign is_full   = (count_ff == CNT_FULL);
   assign free_ok   = (mode_ff == MODE_FREE) && handle_ok;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      hint_in       = hint_ff;
      count_in      = count_ff;
      scan_row_in   = scan_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = STATUS_BAD;
      rsp_handle_in = '0;
      rsp_slot_in   = '0;

      gen_rd_en     = 1'b0;
      gen_rd_addr   = req_slot;
      gen_wr_en     = 1'b0;
      gen_wr_addr   = slot_ff;
      gen_wr_data   = gen_rd_data + GEN_BITS'(1);
      alive_rd_en   = 1'b0;
      alive_rd_addr = ROW_W'(req_slot >> WORD_SEL_W);
      alive_wr_en   = 1'b0;
      alive_wr_addr = slot_row;
      alive_wr_data = set_word;

      case (state_ff)
         S_CLEAR: begin
            gen_wr_en     = 1'b1;
            gen_wr_addr   = clr_ff;
            gen_wr_data   = '0;
            alive_wr_en   = 1'b1;
            alive_wr_addr = ROW_W'(clr_ff >> WORD_SEL_W);
            alive_wr_data = '0;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == SLOT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               gen_rd_en   = 1'b1;
               alive_rd_en = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (mode_ff)
                  MODE_ALLOC: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        alive_wr_en   = 1'b1;
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = STATUS_OK;
                        rsp_handle_in = {32'(gen_rd_data), 32'(slot_ff) + 32'd1};
                        rsp_slot_in   = SLOT_IDX_W'(slot_ff);
                        // the slot just taken was the lowest free; find the next one
                        if (count_ff + 1'b1 != CNT_FULL) begin
                           if (exec_pick.found) begin
                              hint_in = SLOT_W'({slot_row, exec_pick.idx});
                           end else begin
                              scan_row_in = next_row;
                              state_in    = S_SCAN_RD;
                           end
                        end
                     end
                  end
                  MODE_RESOLVE: begin
                     if (handle_ok) begin
                        rsp_status_in = STATUS_OK;
                        rsp_slot_in   = SLOT_IDX_W'(slot_ff);
                     end
                  end
                  MODE_FREE: begin
                     if (handle_ok) begin
                        gen_wr_en     = 1'b1;
                        alive_wr_en   = 1'b1;
                        alive_wr_data = alive_rd_data & ~slot_onehot;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                        if (is_full || (slot_ff < hint_ff)) begin
                           hint_in = slot_ff;
                        end
                        rsp_status_in = STATUS_OK;
                        rsp_slot_in   = SLOT_IDX_W'(slot_ff);
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_BAD;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            alive_rd_en   = 1'b1;
            alive_rd_addr = scan_row_ff;
            state_in      = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (scan_pick.found) begin
               hint_in  = SLOT_W'({scan_row_ff, scan_pick.idx});
               state_in = S_IDLE;
            end else begin
               scan_row_in = (scan_row_ff == ROW_LAST) ? '0 : scan_row_ff + 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         count_ff     <= '0;
         scan_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
         scan_row_ff  <= scan_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff     <= req_chan.mode;
         handle_ff   <= req_chan.handle;
         slot_ff     <= req_slot;
         in_range_ff <= req_in_range;
      end
      if (exec_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   gsa_ram #(
      .WIDTH (GEN_BITS),
      .DEPTH (SLOTS)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   gsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROWS)
   ) u_alive_ram (
      .clock   (clock),
      .wr_en   (alive_wr_en),
      .wr_addr (alive_wr_addr),
      .wr_data (alive_wr_data),
      .rd_en   (alive_rd_en),
      .rd_addr (alive_rd_addr),
      .rd_data (alive_rd_data)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.new_handle = rsp_handle_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;
   assign rsp_chan.live_count = rsp_count_ff;

   // live count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("live count above table size");

   // failed requests carry no handle and no slot
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK))
      |-> ((rsp_handle_ff == '0) && (rsp_slot_ff == '0)))
      else $error("failed response carries handle or slot");

   // a successful free drops the count by one
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      (exec_go && free_ok) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("free did not decrement live count");

   // whenever the block is idle, the free-slot hint names a slot inside the table
   a_hint_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (hint_ff <= SLOT_LAST))
      else $error("free-slot hint out of range");

endmodule

FILE: sim/tb_generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_generational_slot_allocator
// Self-checking bench for the slot allocator. A directed table covers the
// reset state, handle extremes, error codes and mode three. Random traffic
// then runs mostly on live handles, with stale and malformed ones mixed in,
// under three sender/receiver idle mixes and one long response stall. The
// top slot is probed with a handle index at its upper limit. Each response
// is compared with the table row if typed, else with the bench's allocator model.
// ----------------------------------------------------------------------------
module tb_generational_slot_allocator;
   import gsa_pkg::*;

   localparam int SLOT_COUNT = 4096;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [HANDLE_W-1:0]   new_handle;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [COUNT_W-1:0]    live_count;
   } slot_reply_type;

   typedef struct {
      logic [MODE_W-1:0]     mode;
      logic [HANDLE_W-1:0]   handle;
      bit                    typed;
      logic [STATUS_W-1:0]   status;
      logic [HANDLE_W-1:0]   new_handle;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [COUNT_W-1:0]    live_count;
   } directed_row_type;

   logic clock;
   logic reset;

   gsa_req_if req_if ();
   gsa_rsp_if rsp_if ();

   generational_slot_allocator #(
      .SLOTS    (SLOT_COUNT),
      .GEN_BITS (32)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // allocator model
   bit                  slot_alive [SLOT_COUNT];
   logic [31:0]         slot_gen   [SLOT_COUNT];
   int unsigned         live_total;
   logic [HANDLE_W-1:0] live_handles [$];

   slot_reply_type expected_replies [$];
   slot_reply_type oldest_reply;
   bit             mismatch_seen;

   int unsigned src_idle_pct;
   int unsigned snk_idle_pct;
   int unsigned stall_request;

   // untyped rows are checked against the model only
   directed_row_type directed_rows [23] = '{
      '{MODE_ALLOC,   64'h0,                   1, STATUS_OK,  64'h1, 12'd0, 13'd1},
      '{MODE_ALLOC,   64'h0,                   1, STATUS_OK,  64'h2, 12'd1, 13'd2},
      '{MODE_RESOLVE, 64'h1,                   1, STATUS_OK,  64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'h0,                   1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'h1001,                1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'h0000_0000_FFFF_FFFF, 1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'h0000_0001_0000_0001, 1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'hFFFF_FFFF_0000_0001, 1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'h3,                   1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_RESOLVE, 64'h1000,                1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_FREE,    64'h1,                   1, STATUS_OK,  64'h0, 12'd0, 13'd1},
      '{MODE_RESOLVE, 64'h1,                   1, STATUS_BAD, 64'h0, 12'd0, 13'd1},
      '{MODE_FREE,    64'h1,                   1, STATUS_BAD, 64'h0, 12'd0, 13'd1},
      '{MODE_ALLOC,   64'h0,                   0, STATUS_OK,  64'h0, 12'd0, 13'd0},
      '{MODE_RESOLVE, 64'h0000_0001_0000_0001, 0, STATUS_OK,  64'h0, 12'd0, 13'd0},
      '{MODE_UNUSED,  64'h0000_0001_0000_0001, 1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF, 1, STATUS_BAD, 64'h0, 12'd0, 13'd2},
      '{MODE_FREE,    64'h0000_0001_0000_0001, 0, STATUS_OK,  64'h0, 12'd0, 13'd0},
      '{MODE_FREE,    64'h2,                   0, STATUS_OK,  64'h0, 12'd0, 13'd0},
      '{MODE_FREE,    64'h2,                   1, STATUS_BAD, 64'h0, 12'd0, 13'd0},
      '{MODE_ALLOC,   64'h0,                   0, STATUS_OK,  64'h0, 12'd0, 13'd0},
      '{MODE_ALLOC,   64'hFFFF_FFFF_FFFF_FFFF, 0, STATUS_OK,  64'h0, 12'd0, 13'd0},
      '{MODE_FREE,    64'hFFFF_FFFF_FFFF_FFFF, 1, STATUS_BAD, 64'h0, 12'd0, 13'd2}
   };

   function automatic bit handle_is_live(input logic [HANDLE_W-1:0] h,
                                         output int unsigned s);
      logic [31:0] idx;
      idx = h[31:0];
      s   = 0;
      if (idx == 32'd0 || idx > SLOT_COUNT)
         return 1'b0;
      s = idx - 1;
      return slot_alive[s] && (h[63:32] == slot_gen[s]);
   endfunction

   function automatic slot_reply_type predict_reply(input logic [MODE_W-1:0] m,
                                                    input logic [HANDLE_W-1:0] h);
      slot_reply_type r;
      int unsigned    s;
      int             hit_k;
      r.status     = STATUS_BAD;
      r.new_handle = '0;
      r.slot_index = '0;
      hit_k        = -1;
      case (m)
         MODE_ALLOC: begin
            s = SLOT_COUNT;
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
               if (!slot_alive[i]) s = i;
            if (s < SLOT_COUNT) begin
               slot_alive[s] = 1'b1;
               live_total++;
               r.status     = STATUS_OK;
               r.new_handle = {slot_gen[s], 32'(s + 1)};
               r.slot_index = SLOT_IDX_W'(s);
               live_handles.push_back(r.new_handle);
            end else begin
               r.status = STATUS_FULL;
            end
         end
         MODE_RESOLVE: begin
            if (handle_is_live(h, s)) begin
               r.status     = STATUS_OK;
               r.slot_index = SLOT_IDX_W'(s);
            end
         end
         MODE_FREE: begin
            if (handle_is_live(h, s)) begin
               slot_gen[s]   = slot_gen[s] + 32'd1;
               slot_alive[s] = 1'b0;
               if (live_total > 0) live_total--;
               r.status     = STATUS_OK;
               r.slot_index = SLOT_IDX_W'(s);
               foreach (live_handles[k])
                  if (hit_k < 0 && live_handles[k] == h) hit_k = k;
               if (hit_k >= 0) live_handles.delete(hit_k);
            end
         end
         default: ;
      endcase
      r.live_count = COUNT_W'(live_total);
      return r;
   endfunction

   // mostly allocates and live handles; the rest stale, mismatched, out of range or mode three
   function automatic void pick_request(output logic [MODE_W-1:0] m,
                                        output logic [HANDLE_W-1:0] h);
      int unsigned roll;
      int unsigned s;
      int unsigned cap;
      logic [31:0] g;
      roll = $urandom_range(99);
      h    = {$urandom, $urandom};
      m    = MODE_ALLOC;
      if (roll < 30) begin
         m = MODE_ALLOC;
      end else if (roll < 80 && live_handles.size() > 0) begin
         m = (roll < 55) ? MODE_RESOLVE : MODE_FREE;
         h = live_handles[$urandom_range(live_handles.size() - 1)];
      end else if (roll < 88) begin
         cap = (live_total + 3 < SLOT_COUNT) ? live_total + 3 : SLOT_COUNT - 1;
         s   = $urandom_range(cap);
         g   = slot_gen[s];
         case ($urandom_range(2))
            0: g = g - 32'd1;
            1: g = g ^ (32'd1 << $urandom_range(31));
            default: ;
         endcase
         m = $urandom_range(1) ? MODE_RESOLVE : MODE_FREE;
         h = {g, 32'(s + 1)};
      end else if (roll < 95) begin
         case ($urandom_range(3))
            0: h[31:0] = 32'd0;
            1: h[31:0] = 32'(SLOT_COUNT + 1) + $urandom_range(1000);
            2: h[31:0] = 32'hFFFF_FFFF;
            default: ;
         endcase
         if ($urandom_range(1)) h[63:32] = slot_gen[0];
         m = $urandom_range(1) ? MODE_RESOLVE : MODE_FREE;
      end else begin
         m = MODE_UNUSED;
      end
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] m, input logic [HANDLE_W-1:0] h,
                               input bit typed, input slot_reply_type typed_reply);
      slot_reply_type r;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.mode   <= m;
      req_if.handle <= h;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      r = predict_reply(m, h);
      expected_replies.push_back(typed ? typed_reply : r);
   endtask

   task automatic send_random(input int unsigned count);
      logic [MODE_W-1:0]   m;
      logic [HANDLE_W-1:0] h;
      repeat (count) begin
         pick_request(m, h);
         send_request(m, h, 1'b0, '0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("generational_slot_allocator regression: fail");
      $finish;
   end

   // response side: random backpressure, plus long hold-offs on request
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected response: status %0d handle %h slot %0d count %0d",
                   rsp_if.status, rsp_if.new_handle, rsp_if.slot_index, rsp_if.live_count);
            mismatch_seen = 1'b1;
         end else begin
            oldest_reply = expected_replies.pop_front();
            if (rsp_if.status !== oldest_reply.status) begin
               $error("status: expected %0d, actual %0d", oldest_reply.status, rsp_if.status);
               mismatch_seen = 1'b1;
            end
            if (rsp_if.new_handle !== oldest_reply.new_handle) begin
               $error("new_handle: expected %h, actual %h",
                      oldest_reply.new_handle, rsp_if.new_handle);
               mismatch_seen = 1'b1;
            end
            if (rsp_if.slot_index !== oldest_reply.slot_index) begin
               $error("slot_index: expected %0d, actual %0d",
                      oldest_reply.slot_index, rsp_if.slot_index);
               mismatch_seen = 1'b1;
            end
            if (rsp_if.live_count !== oldest_reply.live_count) begin
               $error("live_count: expected %0d, actual %0d",
                      oldest_reply.live_count, rsp_if.live_count);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   initial begin
      slot_reply_type      row_reply;
      logic [HANDLE_W-1:0] h;

      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.mode   = MODE_ALLOC;
      req_if.handle = '0;
      mismatch_seen = 1'b0;
      stall_request = 0;
      src_idle_pct  = 35;
      snk_idle_pct  = 62;
      live_total    = 0;
      foreach (slot_alive[i]) begin
         slot_alive[i] = 1'b0;
         slot_gen[i]   = 32'd0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row_reply = '{directed_rows[i].status, directed_rows[i].new_handle,
                       directed_rows[i].slot_index, directed_rows[i].live_count};
         send_request(directed_rows[i].mode, directed_rows[i].handle,
                      directed_rows[i].typed, row_reply);
      end

      send_random(220);

      src_idle_pct = 62;
      snk_idle_pct = 35;
      send_random(40);
      // hold responses off long enough for the block to back up its input
      stall_request = 400;
      send_random(180);

      src_idle_pct = 0;
      snk_idle_pct = 0;
      send_random(120);

      // top slot: handle index at its upper limit
      h = {slot_gen[SLOT_COUNT-1], 32'(SLOT_COUNT)};
      send_request(MODE_RESOLVE, h, 1'b0, '0);
      send_request(MODE_FREE, h, 1'b0, '0);
      send_request(MODE_RESOLVE, h, 1'b0, '0);
      send_request(MODE_ALLOC, '0, 1'b0, '0);
      send_random(60);

      @(negedge clock);
      req_if.valid <= 1'b0;

      while (expected_replies.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      if (!mismatch_seen && expected_replies.size() == 0)
         $display("generational_slot_allocator regression: pass");
      else
         $display("generational_slot_allocator regression: fail");
      $finish;
   end

endmodule

FILE: files.f
hdl/gsa_pkg.sv
hdl/gsa_req_if.sv
hdl/gsa_rsp_if.sv
hdl/gsa_ram.sv
hdl/generational_slot_allocator.sv
sim/tb_generational_slot_allocator.sv
